// ===== src/umsr_pkg.sv =====
// ----------------------------------------------------------------------------
// USB-MIDI SysEx reassembler package
// Shared constants, packet code indices and controller state type.
// ----------------------------------------------------------------------------
package umsr_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 64;

  localparam logic [3:0] CIN_SYSEX_START = 4'h4;
  localparam logic [3:0] CIN_SYSEX_END1  = 4'h5;
  localparam logic [3:0] CIN_SYSEX_END2  = 4'h6;
  localparam logic [3:0] CIN_SYSEX_END3  = 4'h7;

  localparam logic KIND_MESSAGE  = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_EMIT,
    ST_OVF
  } state_t;

endpackage

// ===== src/usb_midi_sysex_reassembler.sv =====
// ----------------------------------------------------------------------------
// USB-MIDI SysEx reassembler
// Collects system exclusive bytes from USB-MIDI event packets in a byte
// memory and reads out each completed message, one byte per request.
// ----------------------------------------------------------------------------
// A SysEx packet is accepted while idle and its bytes are then appended one
// at a time, since the message memory has a single write port. Other code
// indices are taken while idle and ignored. An end packet then reads the
// message out byte by byte via a read state, for the registered memory read,
// and an emit state that waits out any output stall. A packet that would
// overrun the buffer yields one overflow request, or the stored message if it
// is an end packet. No clearing pass is needed after reset.
module usb_midi_sysex_reassembler
  import umsr_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_code_index,
  input  logic [7:0] in_first_byte,
  input  logic [7:0] in_second_byte,
  input  logic [7:0] in_third_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_message_byte,
  output logic       out_last_byte,
  output logic       out_kind
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned FW = $clog2(BUFFER_BYTES + 1);

  logic [7:0] mem [BUFFER_BYTES];

  state_t        state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] rd_idx_r, rd_idx_nxt;
  logic [1:0]    wr_k_r, wr_k_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          end_r, end_nxt;
  logic [7:0]    b0_r, b0_nxt, b1_r, b1_nxt, b2_r, b2_nxt;
  logic [7:0]    rd_data_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_kind_r, out_kind_nxt;

  logic          mem_we;
  logic [7:0]    mem_wd;
  logic [1:0]    in_cnt;
  logic [FW:0]   fill_sum;
  logic          out_free;
  logic          rd_last;

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_message_byte = out_byte_r;
  assign out_last_byte    = out_last_r;
  assign out_kind         = out_kind_r;

  assign out_free = !out_valid_r || !out_stall;
  assign rd_last  = ((rd_idx_r + 1'b1) == fill_r);
  assign fill_sum = {1'b0, fill_r} + {{(FW - 1){1'b0}}, in_cnt};

  always_comb begin
    case (in_code_index)
      CIN_SYSEX_END1: in_cnt = 2'd1;
      CIN_SYSEX_END2: in_cnt = 2'd2;
      default:        in_cnt = 2'd3;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rd_idx_nxt    = rd_idx_r;
    wr_k_nxt      = wr_k_r;
    cnt_nxt       = cnt_r;
    end_nxt       = end_r;
    b0_nxt        = b0_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_kind_nxt  = out_kind_r;
    mem_we        = 1'b0;
    case (wr_k_r)
      2'd0:    mem_wd = b0_r;
      2'd1:    mem_wd = b1_r;
      default: mem_wd = b2_r;
    endcase
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_code_index inside {[CIN_SYSEX_START:CIN_SYSEX_END3]})) begin
          b0_nxt     = in_first_byte;
          b1_nxt     = in_second_byte;
          b2_nxt     = in_third_byte;
          cnt_nxt    = in_cnt;
          end_nxt    = (in_code_index != CIN_SYSEX_START);
          wr_k_nxt   = 2'd0;
          rd_idx_nxt = '0;
          if (fill_sum <= (FW + 1)'(BUFFER_BYTES)) begin
            state_nxt = ST_WRITE;
          end else if (in_code_index != CIN_SYSEX_START) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_OVF;
          end
        end
      end
      ST_WRITE: begin
        mem_we   = 1'b1;
        fill_nxt = fill_r + 1'b1;
        wr_k_nxt = wr_k_r + 2'd1;
        if (wr_k_r == (cnt_r - 2'd1)) begin
          state_nxt = end_r ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data_r;
          out_last_nxt  = rd_last;
          out_kind_nxt  = KIND_MESSAGE;
          if (rd_last) begin
            fill_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
            state_nxt  = ST_READ;
          end
        end
      end
      ST_OVF: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = 8'h00;
          out_last_nxt  = 1'b1;
          out_kind_nxt  = KIND_OVERFLOW;
          fill_nxt      = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    wr_k_r     <= wr_k_nxt;
    cnt_r      <= cnt_nxt;
    end_r      <= end_nxt;
    b0_r       <= b0_nxt;
    b1_r       <= b1_nxt;
    b2_r       <= b2_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_kind_r <= out_kind_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[AW-1:0]] <= mem_wd;
    end
    rd_data_r <= mem[rd_idx_r[AW-1:0]];
  end

endmodule

// ===== src/umsr_checker.sv =====
// ----------------------------------------------------------------------------
// USB-MIDI SysEx reassembler checker
// Port-level checks on the reassembler, attached by a bind statement.
// ----------------------------------------------------------------------------
module umsr_assertions
  import umsr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [3:0] in_code_index,
  input logic [7:0] in_first_byte,
  input logic [7:0] in_second_byte,
  input logic [7:0] in_third_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_message_byte,
  input logic       out_last_byte,
  input logic       out_kind
);

  logic sysex_in;

  assign sysex_in = in_code_index inside {CIN_SYSEX_START, CIN_SYSEX_END1, CIN_SYSEX_END2,
                                          CIN_SYSEX_END3};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_message_byte) &&
    $stable(out_last_byte) && $stable(out_kind))
    else $error("Stalled output request changed.");

  a_ovf_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_OVERFLOW) |-> out_last_byte && (out_message_byte == 8'h00))
    else $error("Overflow request is malformed.");

  a_sysex_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && sysex_in |=> in_stall)
    else $error("SysEx packet was not processed.");

  a_ignore_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !sysex_in |=> !in_stall)
    else $error("Ignored packet stalled the input.");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

endmodule

bind usb_midi_sysex_reassembler umsr_assertions u_umsr_assertions (.*);

// ===== dv/umsr_checker.sv =====
// ----------------------------------------------------------------------------
// USB-MIDI SysEx reassembler checker
// Watches the packet and result channels, rebuilds the expected result stream
// from every accepted packet and compares each accepted result against it.
// ----------------------------------------------------------------------------
module umsr_checker
  import umsr_pkg::*;
#(
  parameter int unsigned DEPTH = BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [3:0] in_code_index,
  input  logic [7:0] in_first_byte,
  input  logic [7:0] in_second_byte,
  input  logic [7:0] in_third_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_message_byte,
  input  logic       out_last_byte,
  input  logic       out_kind,
  output int         mismatches,
  output int         pending,
  output int         messages_done,
  output int         overflows_done
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       kind;
  } sysex_result_t;

  sysex_result_t awaited_bytes[$];
  sysex_result_t want;
  logic [7:0]    shadow_store [DEPTH];
  int unsigned   shadow_fill;

  initial begin
    mismatches     = 0;
    pending        = 0;
    messages_done  = 0;
    overflows_done = 0;
    shadow_fill    = 0;
  end

  task automatic reassemble_packet(input logic [3:0] cin, input logic [7:0] b0,
                                   input logic [7:0] b1, input logic [7:0] b2);
    logic [7:0]  bytes [3];
    int unsigned count;
    bit          overrun;
    bytes[0] = b0;
    bytes[1] = b1;
    bytes[2] = b2;
    overrun  = 1'b0;
    case (cin)
      CIN_SYSEX_START, CIN_SYSEX_END3: count = 3;
      CIN_SYSEX_END1: count = 1;
      CIN_SYSEX_END2: count = 2;
      default: return;
    endcase
    if (shadow_fill + count <= DEPTH) begin
      for (int i = 0; i < count; i++) shadow_store[shadow_fill + i] = bytes[i];
      shadow_fill += count;
    end else begin
      overrun = 1'b1;
    end
    // An end packet always flushes what is stored, even when its own bytes
    // did not fit.
    if (cin != CIN_SYSEX_START) begin
      for (int i = 0; i < shadow_fill; i++)
        awaited_bytes.push_back({shadow_store[i], (i + 1 == shadow_fill), KIND_MESSAGE});
      shadow_fill = 0;
    end else if (overrun) begin
      awaited_bytes.push_back({8'h00, 1'b1, KIND_OVERFLOW});
      shadow_fill = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_fill = 0;
      awaited_bytes.delete();
    end else begin
      if (in_valid && !in_stall)
        reassemble_packet(in_code_index, in_first_byte, in_second_byte, in_third_byte);
      if (out_valid && !out_stall) begin
        if (awaited_bytes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected request: byte %h last %b kind %b", $time,
                   out_message_byte, out_last_byte, out_kind);
        end else begin
          want = awaited_bytes.pop_front();
          if (out_message_byte !== want.data) begin
            mismatches++;
            $display("%0t: message byte expected %h actual %h", $time, want.data,
                     out_message_byte);
          end
          if (out_last_byte !== want.last) begin
            mismatches++;
            $display("%0t: last flag expected %b actual %b", $time, want.last,
                     out_last_byte);
          end
          if (out_kind !== want.kind) begin
            mismatches++;
            $display("%0t: kind expected %b actual %b", $time, want.kind, out_kind);
          end
          if (want.kind == KIND_OVERFLOW) overflows_done++;
          else if (want.last) messages_done++;
        end
      end
    end
    pending = awaited_bytes.size();
  end

endmodule

// ===== dv/tb_usb_midi_sysex_reassembler.sv =====
// ----------------------------------------------------------------------------
// USB-MIDI SysEx reassembler testbench
// Drives USB-MIDI event packets in bursts: short directed messages, full and
// overrunning buffers, a long output hold-off, then random messages mixed
// with ignored packets. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_usb_midi_sysex_reassembler
  import umsr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] CIN_MISC              = 4'h0;
  localparam logic [3:0] CIN_THREE_BYTE_COMMON = 4'h3;
  localparam logic [3:0] CIN_NOTE_OFF          = 4'h8;
  localparam logic [3:0] CIN_SINGLE_BYTE       = 4'hf;

  localparam int HOLD_CYCLES  = 500;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEM_TARGET  = 270;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [3:0] in_code_index;
  logic [7:0] in_first_byte;
  logic [7:0] in_second_byte;
  logic [7:0] in_third_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_message_byte;
  logic       out_last_byte;
  logic       out_kind;

  int mismatches;
  int pending;
  int messages_done;
  int overflows_done;
  int sysex_sent;
  int noise_sent;
  int burst_left;
  int idle_cycles;
  int rx_mode;
  int rx_left;
  bit hold_req;
  bit hold_done;

  usb_midi_sysex_reassembler DUT (.*);

  umsr_checker u_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [3:0] rand_end();
    case ($urandom_range(0, 2))
      0: return CIN_SYSEX_END1;
      1: return CIN_SYSEX_END2;
      default: return CIN_SYSEX_END3;
    endcase
  endfunction

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      drop_valid();
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic push_packet(input logic [3:0] cin, input logic [7:0] b0,
                             input logic [7:0] b1, input logic [7:0] b2);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_code_index  <= cin;
    in_first_byte  <= b0;
    in_second_byte <= b1;
    in_third_byte  <= b2;
    do @(posedge clk); while (in_stall);
    case (cin)
      CIN_SYSEX_START, CIN_SYSEX_END1, CIN_SYSEX_END2, CIN_SYSEX_END3: sysex_sent++;
      default: noise_sent++;
    endcase
    pace();
  endtask

  task automatic send_noise();
    logic [3:0] code;
    code = 4'($urandom_range(0, 11));
    if (code >= 4'd4) code = code + 4'd4;
    push_packet(code, rand_byte(), rand_byte(), rand_byte());
  endtask

  task automatic send_message(input int starts, input logic [3:0] end_cin,
                              input bit closed, input bit noisy);
    for (int i = 0; i < starts; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_noise();
      push_packet(CIN_SYSEX_START, rand_byte(), rand_byte(), rand_byte());
    end
    if (closed) push_packet(end_cin, rand_byte(), rand_byte(), rand_byte());
  endtask

  task automatic drain();
    drop_valid();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    out_stall = 1'b0;
    rx_left   = 0;
    rx_mode   = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles.", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sel;
    int starts;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_code_index  = CIN_MISC;
    in_first_byte  = 8'h00;
    in_second_byte = 8'h00;
    in_third_byte  = 8'h00;
    hold_req       = 1'b0;
    sysex_sent     = 0;
    noise_sent     = 0;
    burst_left     = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_packet(CIN_MISC, 8'hff, 8'hff, 8'hff);
    push_packet(CIN_SINGLE_BYTE, 8'h00, 8'h00, 8'h00);
    push_packet(CIN_SYSEX_START, 8'hff, 8'hff, 8'hff);
    push_packet(CIN_SYSEX_END1, 8'h00, 8'hff, 8'hff);
    push_packet(CIN_SYSEX_END2, 8'h00, 8'hff, 8'h5a);
    push_packet(CIN_SYSEX_END3, 8'h00, 8'h80, 8'h7f);
    push_packet(CIN_SYSEX_START, 8'hf0, 8'h7e, 8'h00);
    push_packet(CIN_THREE_BYTE_COMMON, 8'h90, 8'h3c, 8'h7f);
    push_packet(CIN_NOTE_OFF, 8'h80, 8'h3c, 8'h00);
    push_packet(CIN_SYSEX_START, 8'h01, 8'h02, 8'h03);
    push_packet(CIN_SYSEX_END2, 8'h55, 8'haa, 8'h00);
    drain();

    // Exact fill, end packets that overrun, and a start packet that overruns.
    send_message(21, CIN_SYSEX_END1, 1'b1, 1'b0);
    send_message(21, CIN_SYSEX_END2, 1'b1, 1'b0);
    send_message(21, CIN_SYSEX_END3, 1'b1, 1'b0);
    send_message(22, CIN_SYSEX_END1, 1'b0, 1'b0);
    send_message(1, CIN_SYSEX_END1, 1'b1, 1'b0);
    drain();

    hold_req = 1'b1;
    send_message(21, CIN_SYSEX_END1, 1'b1, 1'b0);
    send_message(6, rand_end(), 1'b1, 1'b1);
    drain();

    while (sysex_sent + noise_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        repeat ($urandom_range(1, 4)) send_noise();
      end else begin
        if (sel < 70) starts = $urandom_range(0, 4);
        else if (sel < 88) starts = $urandom_range(5, 19);
        else starts = $urandom_range(20, 23);
        send_message(starts, rand_end(), $urandom_range(0, 9) != 0, 1'b1);
      end
      if ($urandom_range(0, 15) == 0) drain();
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d SysEx packets and %0d ignored packets, including a long output hold-off.",
             sysex_sent, noise_sent);
    $display("Checked %0d complete messages and %0d overflow results.", messages_done,
             overflows_done);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
